[src/stkspan_pkg.sv]
// Package holding the request and result types, the state type and fixed widths of the stock span core.
package stkspan_pkg;

	localparam int unsigned PRICE_W = 20;
	localparam int unsigned SPAN_W  = 11;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic               new_sequence;
	} stkspan_in_t;

	typedef struct packed {
		logic [SPAN_W-1:0] span;
		logic              overflow;
	} stkspan_out_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} stkspan_state_t;

endpackage

[src/stock_span_monotonic_stack_core.sv]
// Stock span core: monotonic stack of earlier days kept in a synchronous memory.
//
//  channel | handshake             | payload                     | direction
//  --------+-----------------------+-----------------------------+----------
//  in      | in_valid / in_ready   | in_data   (stkspan_in_t)    | request in
//  out     | out_valid / out_ready | out_data  (stkspan_out_t)   | result out
//
// A request is taken in the idle state and then scanned; each pop reads the entry
// below through the single read port of the stack memory, whose data is used in
// the next cycle. Each day is pushed once, so pops average below one per request.
// Reset clears the stack count, the day count, the overflow flag, the state and
// the output valid flag; the stack memory itself is not cleared, as only entries
// below the count are ever read. A result waits in the output register while the
// next request is taken and scanned; the scan stalls at its final cycle only if the
// previous result has still not left.
module stock_span_monotonic_stack_core
	import stkspan_pkg::*;
#(
	parameter int unsigned MAX_DAYS   = 1024,
	parameter int unsigned PRICE_BITS = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  stkspan_in_t  in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output stkspan_out_t out_data
);

	// Day numbers and the stack count run up to MAX_DAYS inclusive.
	localparam int unsigned DW = $clog2(MAX_DAYS + 1);
	// Stack memory address.
	localparam int unsigned AW = $clog2(MAX_DAYS);
	localparam int unsigned PW = PRICE_BITS;
	localparam logic [DW-1:0] MAX_D = DW'(MAX_DAYS);

	typedef struct packed {
		logic [DW-1:0] day;
		logic [PW-1:0] price;
	} entry_t;

	// Stack storage: entry k holds the (k+1)-th day from the bottom of the stack.
	entry_t stack_mem [MAX_DAYS];

	stkspan_state_t state_q, state_d;
	logic [DW-1:0]  count_q;
	logic [DW-1:0]  day_q;
	logic           ovf_q;
	logic [PW-1:0]  price_q;
	entry_t         top_q;
	entry_t         rd_data_q;
	logic           use_rd_q;
	logic           out_valid_q;
	stkspan_out_t   out_data_q;

	logic          accept;
	logic          out_free;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [DW-1:0] rd_idx;
	logic          pop;
	logic          push;
	logic          emit;
	entry_t        top_cur;
	logic [DW-1:0] today;
	logic [DW-1:0] span_d;
	logic [31:0]   span_wide;
	logic [31:0]   price_wide;
	logic [PW-1:0] price_in;
	logic [DW-1:0] day_start;

	// The incoming price keeps only its low PRICE_BITS bits; wider settings zero-extend.
	always_comb begin
		price_wide = 32'(in_data.price);
		price_in   = price_wide[PW-1:0];
	end

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// The top of stack comes straight from the memory in the cycle after a pop issued
	// its read, and from the register otherwise.
	assign top_cur = use_rd_q ? rd_data_q : top_q;
	assign today   = day_q + DW'(1);
	assign rd_idx  = count_q - DW'(2);
	assign span_d  = (count_q == '0) ? today : (today - top_cur.day);

	always_comb begin
		span_wide = 32'(span_d);
	end

	// A new sequence restarts the day count, so it can never overflow.
	assign day_start = in_data.new_sequence ? '0 : day_q;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		pop      = 1'b0;
		push     = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (ovf_q) begin
					if (out_free) begin
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
				end else if (count_q != '0 && top_cur.price <= price_q) begin
					// Pop the top; fetch the entry beneath it if there is one.
					pop = 1'b1;
					if (count_q >= DW'(2)) begin
						rd_en   = 1'b1;
						rd_addr = rd_idx[AW-1:0];
					end
				end else if (out_free) begin
					push    = 1'b1;
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			day_q       <= '0;
			ovf_q       <= 1'b0;
			use_rd_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			use_rd_q <= rd_en;
			if (accept) begin
				ovf_q <= (day_start == MAX_D);
				if (in_data.new_sequence) begin
					count_q <= '0;
					day_q   <= '0;
				end
			end else if (pop) begin
				count_q <= count_q - DW'(1);
			end else if (push) begin
				count_q <= count_q + DW'(1);
				day_q   <= today;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			price_q <= price_in;
		end
		if (state_q == ST_SCAN) begin
			if (push) begin
				top_q <= '{day: today, price: price_q};
			end else begin
				top_q <= top_cur;
			end
		end
		if (emit) begin
			out_data_q.overflow <= ovf_q;
			out_data_q.span     <= ovf_q ? '0 : span_wide[SPAN_W-1:0];
		end
	end

	// Reads and writes never meet on one entry: a push ends a request and the next
	// request reads only after its own first cycle, always below the pushed entry.
	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[count_q[AW-1:0]] <= '{day: today, price: price_q};
		end
		if (rd_en) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[dv/tb_stock_span_monotonic_stack_core.sv]
// Self-checking testbench for the stock span core: random handshakes, span prediction, checks.
module tb_stock_span_monotonic_stack_core;
	import stkspan_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The core is built with its default sizes; the predictor shares them.
	localparam int unsigned DAY_LIMIT   = 1024;
	localparam int unsigned PRICE_MAX   = (1 << PRICE_W) - 1;
	localparam int unsigned RANDOM_REQS = 100;
	// The slowest honest run has about 1300 requests, each waiting out the longest send
	// gap and receive stall plus its own pops, so this leaves a wide margin.
	localparam int unsigned CYCLE_LIMIT  = 300_000;
	// Run on once nothing is expected, so the core can settle back to idle.
	localparam int unsigned DRAIN_CYCLES = 40;

	// How the prices within one random sequence are laid out.
	typedef enum int {
		SHAPE_NOISE,
		SHAPE_NARROW,
		SHAPE_RISE,
		SHAPE_FALL,
		SHAPE_JAGGED
	} price_shape_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         in_valid = 1'b0;
	logic         in_ready;
	stkspan_in_t  in_data = '0;
	logic         out_valid;
	logic         out_ready = 1'b0;
	stkspan_out_t out_data;

	stock_span_monotonic_stack_core #(
		.MAX_DAYS   (DAY_LIMIT),
		.PRICE_BITS (PRICE_W)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Requests waiting to be driven, and the spans we expect back, oldest first.
	stkspan_in_t  pending_reqs[$];
	stkspan_out_t span_expect_q[$];

	// Our own copy of the core's state: the days still on the monotonic stack, with
	// their prices, and the number of days seen in the current sequence.
	int unsigned        held_day[DAY_LIMIT];
	logic [PRICE_W-1:0] held_price[DAY_LIMIT];
	int unsigned        held_days = 0;
	int unsigned        day_num = 0;

	int unsigned failures = 0;
	int unsigned reqs_sent = 0;
	int unsigned results_checked = 0;
	int unsigned overflow_seen = 0;
	int unsigned peak_span = 0;
	int unsigned peak_depth = 0;
	int unsigned cycle_count = 0;

	// Works out the span of one request and moves the stack on, exactly as the core
	// should. A full sequence leaves the state alone and reports overflow instead.
	function automatic stkspan_out_t predict_span(stkspan_in_t req);
		stkspan_out_t res = '0;
		int unsigned today;
		if (req.new_sequence) begin
			held_days = 0;
			day_num = 0;
		end
		if (day_num >= DAY_LIMIT) begin
			res.overflow = 1'b1;
			return res;
		end
		today = day_num + 1;
		// Earlier days priced at or below today fall inside today's span.
		while (held_days > 0 && held_price[held_days-1] <= req.price)
			held_days--;
		if (held_days == 0)
			res.span = SPAN_W'(today);
		else
			res.span = SPAN_W'(today - held_day[held_days-1]);
		if (held_days < DAY_LIMIT) begin
			held_day[held_days] = today;
			held_price[held_days] = req.price;
			held_days++;
		end
		day_num = today;
		if (res.span > peak_span)
			peak_span = res.span;
		if (held_days > peak_depth)
			peak_depth = held_days;
		return res;
	endfunction

	// Number of idle cycles before the next request or result. Now and then a side
	// enters a calm stretch in which it never idles, so back-to-back traffic occurs too.
	function automatic int unsigned draw_wait(inout int unsigned calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm_left = $urandom_range(20, 80);
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 19);
	endfunction

	task automatic queue_request(int unsigned price, bit fresh);
		stkspan_in_t req;
		req.price = PRICE_W'(price);
		req.new_sequence = fresh;
		pending_reqs.push_back(req);
	endtask

	// Queues one sequence of the given shape. The first request may carry the
	// new-sequence flag; without it the days simply carry on from the previous run.
	task automatic queue_sequence(price_shape_t shape, int unsigned len, bit fresh_start);
		int unsigned walk;
		int unsigned delta;
		walk = $urandom_range(0, PRICE_MAX);
		for (int unsigned i = 0; i < len; i++) begin
			delta = $urandom_range(0, 4000);
			case (shape)
				SHAPE_NOISE: begin
					walk = $urandom_range(0, PRICE_MAX);
				end
				SHAPE_NARROW: begin
					// A tiny range gives many equal prices.
					walk = $urandom_range(0, 7);
				end
				SHAPE_RISE: begin
					walk = (walk > PRICE_MAX - delta) ? PRICE_MAX : walk + delta;
				end
				SHAPE_FALL: begin
					walk = (walk < delta) ? 0 : walk - delta;
				end
				default: begin
					if ($urandom_range(0, 1) == 0)
						walk = (walk > PRICE_MAX - delta) ? PRICE_MAX : walk + delta;
					else
						walk = (walk < delta) ? 0 : walk - delta;
				end
			endcase
			queue_request(walk, fresh_start && i == 0);
		end
	endtask

	// Stimulus and end of run.
	initial begin
		int unsigned walk;
		int unsigned random_total;
		int unsigned len;
		price_shape_t shape;

		// Directed opening. The core has just come out of reset, so the first day
		// counts as day one even though the new-sequence flag is clear.
		queue_request(500, 1'b0);
		queue_request(500, 1'b0);           // equal price is popped and counted
		queue_request(PRICE_MAX, 1'b0);     // highest price swallows everything
		queue_request(0, 1'b0);
		queue_request(0, 1'b0);
		queue_request(PRICE_MAX, 1'b0);     // equal to a held maximum
		queue_request(0, 1'b1);             // restart mid-sequence with entries still on the stack
		// The textbook week of prices.
		queue_request(100, 1'b1);
		queue_request(80, 1'b0);
		queue_request(60, 1'b0);
		queue_request(70, 1'b0);
		queue_request(60, 1'b0);
		queue_request(75, 1'b0);
		queue_request(85, 1'b0);
		// Alternating bit patterns and corner values in the price field.
		queue_request(20'h55555, 1'b1);
		queue_request(20'hAAAAA, 1'b0);
		queue_request(20'h00001, 1'b0);
		queue_request(20'h80000, 1'b0);
		queue_request(20'h7FFFF, 1'b0);

		// A strictly falling run over all but the last day of a full sequence deepens
		// the stack to one short of the brim. The last day matches the first day's
		// price, so it pops the whole stack and reaches the largest possible span.
		// The requests after it overflow until a new sequence is flagged.
		walk = PRICE_MAX;
		for (int unsigned i = 0; i + 1 < DAY_LIMIT; i++) begin
			queue_request(walk, i == 0);
			walk -= $urandom_range(1, 1000);
		end
		queue_request(PRICE_MAX, 1'b0);
		for (int unsigned i = 0; i < 6; i++)
			queue_request($urandom_range(0, PRICE_MAX), 1'b0);
		queue_request(PRICE_MAX, 1'b0);
		// The flag starts again even when the sequence is full.
		queue_request($urandom_range(0, PRICE_MAX), 1'b1);

		// Random part: mostly short, well-formed sequences of varied shape, some
		// running on without the flag, plus the odd stray restart.
		random_total = 0;
		while (random_total < RANDOM_REQS) begin
			if ($urandom_range(0, 11) == 0) begin
				queue_request($urandom_range(0, PRICE_MAX), 1'b1);
				random_total++;
			end else begin
				shape = price_shape_t'($urandom_range(0, 4));
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				                                 : $urandom_range(1, 30);
				queue_sequence(shape, len, $urandom_range(0, 9) != 0);
				random_total += len;
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every request has gone in and every span has come back.
		@(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || span_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests, checked %0d spans, %0d of them overflows.",
		         reqs_sent, results_checked, overflow_seen);
		$display("Largest span %0d, deepest stack %0d entries, %0d mismatches.",
		         peak_span, peak_depth, failures);
		if (failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Request driver. A request is predicted on the edge at which the core takes it;
	// valid and payload are held steady until then. After each request a fresh idle
	// count is drawn, so gaps land in every phase of the core's scan.
	int unsigned send_wait = 0;
	int unsigned send_calm = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				span_expect_q.push_back(predict_span(in_data));
				reqs_sent++;
			end
			if (send_wait > 0 || pending_reqs.size() == 0) begin
				if (send_wait > 0)
					send_wait--;
				in_valid <= 1'b0;
			end else begin
				in_data <= pending_reqs.pop_front();
				in_valid <= 1'b1;
				send_wait = draw_wait(send_calm);
			end
		end
	end

	// Result monitor. Ready may drop for a drawn number of cycles after each result, which
	// also stalls the core while it scans the next request.
	int unsigned take_wait = 0;
	int unsigned take_calm = 0;

	always @(posedge clk or negedge arst_n) begin
		stkspan_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (span_expect_q.size() == 0) begin
					$error("result with nothing expected: span %0d, overflow %0b",
					       out_data.span, out_data.overflow);
					failures++;
				end else begin
					want = span_expect_q.pop_front();
					if (out_data.span !== want.span) begin
						$error("span: expected %0d, got %0d", want.span, out_data.span);
						failures++;
					end
					if (out_data.overflow !== want.overflow) begin
						$error("overflow: expected %0b, got %0b",
						       want.overflow, out_data.overflow);
						failures++;
					end
					results_checked++;
					if (want.overflow)
						overflow_seen++;
				end
				take_wait = draw_wait(take_calm);
				out_ready <= (take_wait == 0);
			end else if (!out_ready) begin
				// Ready is already low when this runs, so the last step of the wait raises it.
				if (take_wait <= 1) begin
					take_wait = 0;
					out_ready <= 1'b1;
				end else begin
					take_wait--;
				end
			end
		end
	end

	// Watchdog: a hung handshake must still end the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d spans outstanding.",
			         cycle_count, span_expect_q.size());
			$display("status: fail");
			$finish;
		end
	end

endmodule
